// ===== rtl/core/itps_pkg.sv =====
// ----------------------------------------------------------------------------
// itps_pkg: shared types and constants of the inertia tensor block
// Field widths, sum slot codes, the job that travels from front to back,
// and the state type of the scaling sequencer.
// ----------------------------------------------------------------------------
package itps_pkg;

	localparam int COORD_W   = 24;               // Q12.12 coordinate
	localparam int OFS_W     = COORD_W + 1;      // exact vertex - centre
	localparam int PROD_W    = 2 * OFS_W;        // exact Q26.24 product
	localparam int SUM_W     = 64;               // Q40.24 sum / result
	localparam int MASS_W    = 32;               // Q16.16 mass
	localparam int CNT_W     = 13;               // vertex count
	localparam int NUM_SUMS  = 6;
	localparam int SLOT_W    = 3;
	localparam int REG_IDX_W = 2;

	// scaled product: |S| (63 bits) times mass, then the 2^16 of the divisor
	localparam int MPROD_W    = SUM_W - 1 + MASS_W;
	localparam int MASS_FRAC  = 16;
	localparam int DIVIDEND_W = MPROD_W - MASS_FRAC;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	// sum slots and tensor entries share one order
	localparam logic [SLOT_W-1:0] IDX_XX = 3'd0;
	localparam logic [SLOT_W-1:0] IDX_YY = 3'd1;
	localparam logic [SLOT_W-1:0] IDX_ZZ = 3'd2;
	localparam logic [SLOT_W-1:0] IDX_XY = 3'd3;
	localparam logic [SLOT_W-1:0] IDX_XZ = 3'd4;
	localparam logic [SLOT_W-1:0] IDX_YZ = 3'd5;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_X   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_Y   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_Z   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_TOTAL_MASS = 2'd3;

	localparam logic [MASS_W-1:0] MASS_RESET = 32'h0001_0000;

	typedef logic [NUM_SUMS-1:0][SUM_W-1:0] sums_t;

	// one finished body, handed from front to back
	typedef struct packed {
		sums_t            sums;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PICK,
		BK_ABS,
		BK_MUL,
		BK_ADD,
		BK_DIV,
		BK_SAT,
		BK_DONE
	} back_state_t;

endpackage

// ===== rtl/core/itps_front.sv =====
// ----------------------------------------------------------------------------
// itps_front: vertex accumulation front end
// Offsets, six products and six running sums, one vertex per cycle; a
// vertex flagged last hands the finished sums to the job queue.
// ----------------------------------------------------------------------------
module itps_front #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [itps_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [itps_pkg::COORD_W-1:0] vertex_y,
	input  logic signed [itps_pkg::COORD_W-1:0] vertex_z,
	input  logic                          last_vertex,
	input  logic signed [itps_pkg::COORD_W-1:0] centre_x,
	input  logic signed [itps_pkg::COORD_W-1:0] centre_y,
	input  logic signed [itps_pkg::COORD_W-1:0] centre_z,
	output logic [1:0]                    lasts_in_flight,
	output logic                          push,
	output itps_pkg::job_t                push_job
);
	import itps_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

	logic                    vld_s1, last_s1;
	logic signed [OFS_W-1:0] dx_s1, dy_s1, dz_s1;
	logic                    vld_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2 [NUM_SUMS];

	sums_t            sums_q, sums_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic             ovf_q, ovf_nxt;
	logic             room;

	// stage 1: offsets from the centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			last_s1 <= accept & last_vertex;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_s1 <= $signed({vertex_x[COORD_W-1], vertex_x}) -
			         $signed({centre_x[COORD_W-1], centre_x});
			dy_s1 <= $signed({vertex_y[COORD_W-1], vertex_y}) -
			         $signed({centre_y[COORD_W-1], centre_y});
			dz_s1 <= $signed({vertex_z[COORD_W-1], vertex_z}) -
			         $signed({centre_z[COORD_W-1], centre_z});
		end
	end

	// stage 2: squares and cross products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2[IDX_XX] <= dx_s1 * dx_s1;
			prod_s2[IDX_YY] <= dy_s1 * dy_s1;
			prod_s2[IDX_ZZ] <= dz_s1 * dz_s1;
			prod_s2[IDX_XY] <= dx_s1 * dy_s1;
			prod_s2[IDX_XZ] <= dx_s1 * dz_s1;
			prod_s2[IDX_YZ] <= dy_s1 * dz_s1;
		end
	end

	// stage 3: accumulate, or only flag once the count is at its limit
	assign room = (cnt_q != CNT_MAX);

	always_comb begin
		sums_nxt = sums_q;
		cnt_nxt  = cnt_q;
		ovf_nxt  = ovf_q;
		if (vld_s2) begin
			if (room) begin
				for (int i = 0; i < NUM_SUMS; i++) begin
					sums_nxt[i] = sums_q[i] +
					              {{(SUM_W-PROD_W){prod_s2[i][PROD_W-1]}}, prod_s2[i]};
				end
				cnt_nxt = cnt_q + 1'b1;
			end else begin
				ovf_nxt = 1'b1;
			end
		end
	end

	assign push           = vld_s2 & last_s2;
	assign push_job.sums  = sums_nxt;
	assign push_job.count = cnt_nxt;
	assign push_job.ovf   = ovf_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (push) begin
			sums_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			sums_q <= sums_nxt;
			cnt_q  <= cnt_nxt;
			ovf_q  <= ovf_nxt;
		end
	end

	assign lasts_in_flight = {1'b0, last_s1} + {1'b0, last_s2};

endmodule

// ===== rtl/core/itps_queue.sv =====
// ----------------------------------------------------------------------------
// itps_queue: two-entry job queue
// Holds finished bodies between the accumulation front and the scaler.
// ----------------------------------------------------------------------------
module itps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itps_pkg::job_t push_job,
	input  logic           pop,
	output logic           head_valid,
	output itps_pkg::job_t head_job,
	output logic [1:0]     fill
);
	import itps_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head_valid = (fill_q != 2'd0);
	assign head_job   = mem_q[rd_ptr_q];
	assign fill       = fill_q;

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q != 2'd2))
		else $error("job pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (fill_q != 2'd0))
		else $error("job popped from an empty queue");
`endif

endmodule

// ===== rtl/core/itps_back.sv =====
// ----------------------------------------------------------------------------
// itps_back: tensor entry scaler
// Per entry: pick the sum, take its magnitude, multiply by the mass,
// divide by count * 2^16 one quotient bit a cycle, sign and saturate.
// ----------------------------------------------------------------------------
module itps_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  itps_pkg::job_t               head_job,
	input  logic [itps_pkg::MASS_W-1:0]  total_mass,
	output logic                         pop,
	output logic                         done,
	output itps_pkg::sums_t              res,
	output logic                         ovf
);
	import itps_pkg::*;

	localparam logic [DIVIDEND_W-1:0] POS_MAX = DIVIDEND_W'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic [DIVIDEND_W-1:0] NEG_MAX = DIVIDEND_W'({1'b1, {(SUM_W-1){1'b0}}});

	back_state_t state_q, state_nxt;

	logic [SLOT_W-1:0]     ent_q;
	logic signed [SUM_W-1:0] s_q;
	logic                  neg_q;
	logic [SUM_W-2:0]      mag_q;
	logic [2*MASS_W-1:0]   pp0_q;
	logic [SUM_W-2:0]      pp1_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      div_q;
	logic [DIV_CNT_W-1:0]  bits_q;
	sums_t                 res_q;
	logic                  ovf_q;

	logic [MPROD_W-1:0]    mprod;
	logic [CNT_W:0]        rem_try;
	logic                  rem_ge;
	logic [SUM_W-1:0]      sat_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: if (head_valid) state_nxt = BK_PICK;
			BK_PICK: state_nxt = BK_ABS;
			BK_ABS:  state_nxt = BK_MUL;
			BK_MUL:  state_nxt = BK_ADD;
			BK_ADD:  state_nxt = BK_DIV;
			BK_DIV:  if (bits_q == DIV_CNT_W'(1)) state_nxt = BK_SAT;
			BK_SAT:  state_nxt = (ent_q == IDX_YZ) ? BK_DONE : BK_PICK;
			BK_DONE: state_nxt = BK_IDLE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= IDX_XX;
		end else if (state_q == BK_IDLE) begin
			ent_q <= IDX_XX;
		end else if (state_q == BK_SAT) begin
			ent_q <= ent_q + 1'b1;
		end
	end

	// restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_try = {rem_q, quo_q[DIVIDEND_W-1]};
	assign rem_ge  = (rem_try >= {1'b0, div_q});
	assign mprod   = {{(MPROD_W-2*MASS_W){1'b0}}, pp0_q} + {pp1_q, {MASS_W{1'b0}}};

	always_comb begin
		if (neg_q) begin
			sat_val = (quo_q > NEG_MAX) ? NEG_MAX[SUM_W-1:0] : (SUM_W'(0) - quo_q[SUM_W-1:0]);
		end else begin
			sat_val = (quo_q > POS_MAX) ? POS_MAX[SUM_W-1:0] : quo_q[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_PICK: begin
				case (ent_q)
					IDX_XX:  s_q <= head_job.sums[IDX_YY] + head_job.sums[IDX_ZZ];
					IDX_YY:  s_q <= head_job.sums[IDX_XX] + head_job.sums[IDX_ZZ];
					IDX_ZZ:  s_q <= head_job.sums[IDX_XX] + head_job.sums[IDX_YY];
					IDX_XY:  s_q <= head_job.sums[IDX_XY];
					IDX_XZ:  s_q <= head_job.sums[IDX_XZ];
					default: s_q <= head_job.sums[IDX_YZ];
				endcase
				neg_q <= (ent_q >= IDX_XY);
				div_q <= (head_job.count == '0) ? CNT_W'(1) : head_job.count;
				ovf_q <= head_job.ovf;
			end
			BK_ABS: begin
				if (s_q[SUM_W-1]) begin
					mag_q <= (SUM_W-1)'(-s_q);
					neg_q <= ~neg_q;
				end else begin
					mag_q <= s_q[SUM_W-2:0];
				end
			end
			BK_MUL: begin
				pp0_q <= mag_q[MASS_W-1:0] * total_mass;
				pp1_q <= mag_q[SUM_W-2:MASS_W] * total_mass;
			end
			BK_ADD: begin
				quo_q  <= mprod[MPROD_W-1:MASS_FRAC];
				rem_q  <= '0;
				bits_q <= DIV_CNT_W'(DIVIDEND_W);
			end
			BK_DIV: begin
				rem_q  <= rem_ge ? CNT_W'(rem_try - {1'b0, div_q}) : rem_try[CNT_W-1:0];
				quo_q  <= {quo_q[DIVIDEND_W-2:0], rem_ge};
				bits_q <= bits_q - 1'b1;
			end
			BK_SAT: begin
				res_q[ent_q] <= sat_val;
			end
			default: begin
			end
		endcase
	end

	assign pop  = (state_q == BK_DONE);
	assign done = (state_q == BK_DONE);
	assign res  = res_q;
	assign ovf  = ovf_q;

`ifndef ASSERT_OFF
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_job_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> head_valid)
		else $error("scaler running without a queued job");
`endif

endmodule

// ===== rtl/core/inertia_tensor_of_point_set_top.sv =====
// ----------------------------------------------------------------------------
// inertia_tensor_of_point_set_top: inertia tensor of equal point masses
// Streams Q12.12 vertices, accumulates second moments about a configured
// centre and returns the six unique Q40.24 tensor entries per body.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+------------------------
//  vertex  | vertex_x/y/z, last_vertex                      | start & !busy
//  result  | inertia_xx/yy/zz/xy/xz/yz, too_many_vertices   | done, one cycle, no stall
//  config  | wr_index, wr_data                              | wr_en, no wait
//
// Vertices: one beat per cycle while busy is low; busy only rises when the
//   two-entry job queue plus the last-vertex beats still in the 3-stage
//   accumulator would fill it.
// A last vertex passes the stage 1 and stage 2 registers before stage 3 pushes its body into the job queue.
// The scaler then works through the six entries in turn: per entry a pickup,
//   a magnitude, a multiply and an add state, a 79-step restoring divider
//   and a saturate state, then one result state for the body.
// Reset clears the accumulators, the queue and the scaler; the centre resets
//   to the origin and the total mass to 1.0.
// The result beat is shown for one cycle; the receiver cannot stall it.
//
module inertia_tensor_of_point_set_top #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [itps_pkg::COORD_W-1:0]   vertex_x,
	input  logic signed [itps_pkg::COORD_W-1:0]   vertex_y,
	input  logic signed [itps_pkg::COORD_W-1:0]   vertex_z,
	input  logic                                  last_vertex,
	input  logic                                  wr_en,
	input  logic [itps_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [itps_pkg::MASS_W-1:0]           wr_data,
	output logic                                  done,
	output logic signed [itps_pkg::SUM_W-1:0]     inertia_xx,
	output logic signed [itps_pkg::SUM_W-1:0]     inertia_yy,
	output logic signed [itps_pkg::SUM_W-1:0]     inertia_zz,
	output logic signed [itps_pkg::SUM_W-1:0]     inertia_xy,
	output logic signed [itps_pkg::SUM_W-1:0]     inertia_xz,
	output logic signed [itps_pkg::SUM_W-1:0]     inertia_yz,
	output logic                                  too_many_vertices
);
	import itps_pkg::*;

	// configuration registers
	logic signed [COORD_W-1:0] centre_x_q, centre_y_q, centre_z_q;
	logic [MASS_W-1:0]         total_mass_q;

	logic       accept;
	logic [1:0] lasts_in_flight;
	logic [1:0] fill;
	logic       push, pop, head_valid;
	job_t       push_job, head_job;
	sums_t      res;
	logic       ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q   <= '0;
			centre_y_q   <= '0;
			centre_z_q   <= '0;
			total_mass_q <= MASS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTRE_X:   centre_x_q   <= wr_data[COORD_W-1:0];
				REG_CENTRE_Y:   centre_y_q   <= wr_data[COORD_W-1:0];
				REG_CENTRE_Z:   centre_z_q   <= wr_data[COORD_W-1:0];
				REG_TOTAL_MASS: total_mass_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// a queue slot must be free for every last-vertex beat already taken
	assign busy   = ({1'b0, fill} + {1'b0, lasts_in_flight}) >= 3'd2;
	assign accept = start & ~busy;

	itps_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.vertex_x        (vertex_x),
		.vertex_y        (vertex_y),
		.vertex_z        (vertex_z),
		.last_vertex     (last_vertex),
		.centre_x        (centre_x_q),
		.centre_y        (centre_y_q),
		.centre_z        (centre_z_q),
		.lasts_in_flight (lasts_in_flight),
		.push            (push),
		.push_job        (push_job)
	);

	itps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.fill       (fill)
	);

	itps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.total_mass (total_mass_q),
		.pop        (pop),
		.done       (done),
		.res        (res),
		.ovf        (ovf)
	);

	assign inertia_xx        = res[IDX_XX];
	assign inertia_yy        = res[IDX_YY];
	assign inertia_zz        = res[IDX_ZZ];
	assign inertia_xy        = res[IDX_XY];
	assign inertia_xz        = res[IDX_XZ];
	assign inertia_yz        = res[IDX_YZ];
	assign too_many_vertices = ovf;

endmodule
